// File: hw/rtl/tadh_pkg.sv
// ----------------------------------------------------------------------------
// tadh_pkg: shared constants for the tilt angle core
// Field widths, register codes, CORDIC widths and the atan step table.
// ----------------------------------------------------------------------------
`default_nettype none

package tadh_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 20;
  localparam int IDX_W      = 4;
  localparam int ANG_W      = 9;
  localparam int DB_W       = 7;
  localparam int SETTLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // CORDIC datapath: operands carry 14 fraction bits, angles are Q16 degrees
  localparam int FRAC_SH    = 14;
  localparam int CW         = 33;
  localparam int TW         = 26;
  localparam int ATAN_W     = 22;
  localparam int ATAN_IDX_W = 5;

  localparam logic signed [TW-1:0] DEG180_Q16 = TW'(180 * 65536);
  localparam logic signed [TW-1:0] DEG360_Q16 = TW'(360 * 65536);

  localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90);
  localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180);
  localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270);
  localparam logic [ANG_W-1:0] DEG_359 = ANG_W'(359);
  localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_OFFSET = 2'd2;

  localparam logic [DB_W-1:0]     DEADBAND_RST     = 7'd5;
  localparam logic [SETTLE_W-1:0] SETTLE_LIMIT_RST = 16'd375;
  localparam logic [ANG_W-1:0]    MOUNT_OFFSET_RST = 9'd90;

  // atan(2^-i) in degrees, Q16, rounded
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tadh_if.sv
// ----------------------------------------------------------------------------
// tadh_if: sample and result channels
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tadh_in_if import tadh_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] x_sample;
  logic signed [SAMPLE_W-1:0] z_sample;

  modport source (output valid, output x_sample, output z_sample, input ready);
  modport sink   (input valid, input x_sample, input z_sample, output ready);
endinterface

interface tadh_out_if import tadh_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ANG_W-1:0] tilt_deg;
  logic             holding;

  modport source (output valid, output tilt_deg, output holding, input ready);
  modport sink   (input valid, input tilt_deg, input holding, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tilt_angle_with_deadband_hold_core.sv
// Flow: a sample passes S_PREP, the CORDIC in S_ROT, S_POST and S_HOLD to a
//   valid result; a window-closing item first waits in S_DIV for the
//   reciprocal-multiply mean; a sample on an axis or at zero skips the CORDIC.
// New samples are taken only in S_IDLE, after S_HOLD has passed on the last
//   result; a stalled result holds them off. The CORDIC does a step per cycle.
// Reset: synchronous, sets config to defaults and clears window and hold state.
// ----------------------------------------------------------------------------
// tilt_angle_with_deadband_hold_core: accelerometer tilt angle
// Per-sample and window-mean CORDIC atan2 in degrees, mount offset, deadband hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_angle_with_deadband_hold_core import tadh_pkg::*; #(
  parameter int AVG_LEN      = 10,
  parameter int CORDIC_STEPS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  tadh_in_if.sink                sample_ch,
  tadh_out_if.source             angle_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_PREP, S_ROT, S_POST, S_HOLD
  } state_t;

  state_t state;

  logic [DB_W-1:0]     deadband;
  logic [SETTLE_W-1:0] settle_limit;
  logic [ANG_W-1:0]    mount_offset;

  logic signed [SUM_W-1:0]    x_sum;
  logic signed [SUM_W-1:0]    z_sum;
  logic [IDX_W-1:0]           sample_index;
  logic [ANG_W-1:0]           last_raw_angle;
  logic [ANG_W-1:0]           held_angle;
  logic [SETTLE_W-1:0]        quiet_count;
  logic                       refresh_latched;

  logic signed [SAMPLE_W-1:0] xa;
  logic signed [SAMPLE_W-1:0] za;
  logic [ANG_W-1:0]           raw;
  logic [ANG_W-1:0]           ang;
  logic                       out_valid;
  logic [ANG_W-1:0]           tilt_deg;
  logic                       holding;

  logic                       accept;
  logic signed [SAMPLE_W-1:0] xs;
  logic signed [SAMPLE_W-1:0] zs;
  logic signed [SUM_W-1:0]    x_sum_next;
  logic signed [SUM_W-1:0]    z_sum_next;
  logic                       win_end;

  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] mean_x;
  logic signed [SAMPLE_W-1:0] mean_z;
  logic                       cordic_start;
  logic                       cordic_done;
  logic signed [TW-1:0]       theta;

  logic signed [TW-1:0]       theta_fix;
  logic [TW-17:0]             deg_full;
  logic [ANG_W-1:0]           raw_deg;
  logic [ANG_W-1:0]           off;
  logic [ANG_W:0]             ang_sum;
  logic [ANG_W-1:0]           diff;
  logic                       in_band;
  logic [SETTLE_W-1:0]        quiet_inc;
  logic                       out_free;

  assign accept = sample_ch.valid && sample_ch.ready;
  assign sample_ch.ready = (state == S_IDLE);

  assign angle_ch.valid    = out_valid;
  assign angle_ch.tilt_deg = tilt_deg;
  assign angle_ch.holding  = holding;
  assign out_free = !out_valid || angle_ch.ready;

  always_comb begin
    xs = {sample_ch.x_sample[SAMPLE_W-1:2], 2'b00};
    zs = {sample_ch.z_sample[SAMPLE_W-1:2], 2'b00};
    x_sum_next = x_sum + {{(SUM_W-SAMPLE_W){xs[SAMPLE_W-1]}}, xs};
    z_sum_next = z_sum + {{(SUM_W-SAMPLE_W){zs[SAMPLE_W-1]}}, zs};
    win_end = ({1'b0, sample_index} + (IDX_W+1)'(1)) >= (IDX_W+1)'(AVG_LEN);

    div_start    = accept && win_end;
    cordic_start = (state == S_PREP) && (xa != '0) && (za != '0);

    // wrap negative angle, floor to degrees, pin a full circle to 359
    theta_fix = theta[TW-1] ? theta + DEG360_Q16 : theta;
    deg_full  = theta_fix[TW-1] ? '0 : theta_fix[TW-1:16];
    raw_deg   = (deg_full >= (TW-16)'(DEG_360)) ? DEG_359 : deg_full[ANG_W-1:0];

    off     = (mount_offset >= DEG_360) ? mount_offset - DEG_360 : mount_offset;
    ang_sum = (raw >= off) ? {1'b0, raw} - {1'b0, off}
                           : {1'b0, raw} + {1'b0, DEG_360} - {1'b0, off};

    diff      = (ang >= held_angle) ? ang - held_angle : held_angle - ang;
    in_band   = diff < {{(ANG_W-DB_W){1'b0}}, deadband};
    quiet_inc = quiet_count + 1'b1;
  end

  tadh_div #(.DIVISOR(AVG_LEN)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .sum_x  (x_sum_next),
    .sum_z  (z_sum_next),
    .done   (div_done),
    .mean_x (mean_x),
    .mean_z (mean_z)
  );

  tadh_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .op_x  (xa),
    .op_z  (za),
    .done  (cordic_done),
    .theta (theta)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      deadband        <= DEADBAND_RST;
      settle_limit    <= SETTLE_LIMIT_RST;
      mount_offset    <= MOUNT_OFFSET_RST;
      x_sum           <= '0;
      z_sum           <= '0;
      sample_index    <= '0;
      last_raw_angle  <= '0;
      held_angle      <= '0;
      quiet_count     <= '0;
      refresh_latched <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEADBAND:     deadband     <= cfg_data[DB_W-1:0];
          CFG_SETTLE_LIMIT: settle_limit <= cfg_data[SETTLE_W-1:0];
          CFG_MOUNT_OFFSET: mount_offset <= cfg_data[ANG_W-1:0];
          default: ;
        endcase
      end

      // a new result may replace the one taken on this same edge
      if (state == S_HOLD && out_free) out_valid <= 1'b1;
      else if (angle_ch.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (win_end) begin
              x_sum        <= '0;
              z_sum        <= '0;
              sample_index <= '0;
              state        <= S_DIV;
            end else begin
              x_sum        <= x_sum_next;
              z_sum        <= z_sum_next;
              sample_index <= sample_index + 1'b1;
              xa           <= xs;
              za           <= zs;
              state        <= S_PREP;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            xa    <= mean_x;
            za    <= mean_z;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // axis cases bypass the CORDIC; zero angle keeps the last raw angle
          if (xa == '0) begin
            raw   <= za[SAMPLE_W-1] ? DEG_180 : last_raw_angle;
            state <= S_POST;
          end else if (za == '0) begin
            raw   <= xa[SAMPLE_W-1] ? DEG_270 : DEG_90;
            state <= S_POST;
          end else begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (cordic_done) begin
            raw   <= raw_deg;
            state <= S_POST;
          end
        end
        S_POST: begin
          last_raw_angle <= raw;
          ang            <= ang_sum[ANG_W-1:0];
          state          <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            if (in_band) begin
              holding <= 1'b1;
              if (quiet_inc > settle_limit && !refresh_latched) begin
                quiet_count     <= '0;
                refresh_latched <= 1'b1;
                held_angle      <= ang;
                tilt_deg        <= ang;
              end else begin
                quiet_count <= quiet_inc;
                tilt_deg    <= held_angle;
              end
            end else begin
              quiet_count     <= '0;
              refresh_latched <= 1'b0;
              held_angle      <= ang;
              tilt_deg        <= ang;
              holding         <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tadh_div.sv
// ----------------------------------------------------------------------------
// tadh_div: window mean divider
// Divides both window sums by a constant with a reciprocal multiply,
// truncating toward zero; it registers the magnitudes, then the quotients and done.
// ----------------------------------------------------------------------------
`default_nettype none

module tadh_div import tadh_pkg::*; #(
  parameter int DIVISOR = 10
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  wire signed [SUM_W-1:0]    sum_x,
  input  wire signed [SUM_W-1:0]    sum_z,
  output logic                      done,
  output logic signed [SAMPLE_W-1:0] mean_x,
  output logic signed [SAMPLE_W-1:0] mean_z
);

  // ceil(2^SHIFT / DIVISOR) gives an exact floor quotient for any SUM_W-bit magnitude
  localparam int     LOG_D   = $clog2(DIVISOR);
  localparam int     SHIFT   = SUM_W + LOG_D;
  localparam int     RECIP_W = SHIFT + 1;
  localparam longint RECIP_L =
    ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int     PROD_W  = SUM_W + RECIP_W;

  logic                busy;
  logic [SUM_W-1:0]    mag  [2];
  logic                neg  [2];
  logic [SAMPLE_W-1:0] quot [2];

  logic [SUM_W-1:0]    mag_in [2];
  logic [PROD_W-1:0]   prod   [2];
  logic [SAMPLE_W-1:0] mean   [2];

  always_comb begin
    mag_in[0] = sum_x[SUM_W-1] ? -sum_x : sum_x;
    mag_in[1] = sum_z[SUM_W-1] ? -sum_z : sum_z;
    for (int l = 0; l < 2; l++) begin
      prod[l] = PROD_W'(mag[l]) * PROD_W'(RECIP);
      mean[l] = neg[l] ? -quot[l] : quot[l];
    end
  end

  assign mean_x = mean[0];
  assign mean_z = mean[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start;
      if (start) begin
        busy <= 1'b1;
        for (int l = 0; l < 2; l++) begin
          mag[l] <= mag_in[l];
        end
        neg[0] <= sum_x[SUM_W-1];
        neg[1] <= sum_z[SUM_W-1];
      end else if (busy) begin
        busy <= 1'b0;
        for (int l = 0; l < 2; l++) begin
          quot[l] <= prod[l][SHIFT +: SAMPLE_W];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tadh_cordic.sv
// ----------------------------------------------------------------------------
// tadh_cordic: iterative vectoring CORDIC
// One add/sub and shift step per cycle over a shared datapath; returns the
// accumulated angle of atan2(x, z) in Q16 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module tadh_cordic import tadh_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire signed [SAMPLE_W-1:0]  op_x,
  input  wire signed [SAMPLE_W-1:0]  op_z,
  output logic                       done,
  output logic signed [TW-1:0]       theta
);

  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic signed [CW-1:0] a;
  logic signed [CW-1:0] b;

  logic [ATAN_IDX_W-1:0] sh;
  logic signed [CW-1:0]  sa;
  logic signed [CW-1:0]  sb;
  logic signed [TW-1:0]  atan_ext;
  logic                  b_pos;
  logic signed [CW-1:0]  x_ext;
  logic signed [CW-1:0]  z_ext;

  always_comb begin
    sh       = ATAN_IDX_W'(step);
    sa       = a >>> sh;
    sb       = b >>> sh;
    atan_ext = $signed({{(TW-ATAN_W){1'b0}}, atan_q16(sh)});
    b_pos    = !b[CW-1] && (b != '0);
    x_ext    = {{(CW-SAMPLE_W-FRAC_SH){op_x[SAMPLE_W-1]}}, op_x, {FRAC_SH{1'b0}}};
    z_ext    = {{(CW-SAMPLE_W-FRAC_SH){op_z[SAMPLE_W-1]}}, op_z, {FRAC_SH{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == STEP_W'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        // left half plane: rotate by 180 first
        if (op_z[SAMPLE_W-1]) begin
          a     <= -z_ext;
          b     <= -x_ext;
          theta <= DEG180_Q16;
        end else begin
          a     <= z_ext;
          b     <= x_ext;
          theta <= '0;
        end
      end else if (busy) begin
        if (b_pos) begin
          a     <= a + sb;
          b     <= b - sa;
          theta <= theta + atan_ext;
        end else begin
          a     <= a - sb;
          b     <= b + sa;
          theta <= theta - atan_ext;
        end
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tadh_checker.sv
// ----------------------------------------------------------------------------
// tadh_checker: port-level checks for the tilt angle core
// Tracks beats in flight and checks result range and channel behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tadh_checker import tadh_pkg::*; (
  input wire             clk,
  input wire             rst,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire [ANG_W-1:0] tilt_deg,
  input wire             holding
);

  logic [1:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_beat && !out_beat) begin
      pending <= pending + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending <= pending - 1'b1;
    end
  end

  // one item in work plus one waiting result at most
  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without an accepted sample");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("ready right after a sample beat");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tilt_deg < DEG_360)
    else $error("tilt angle out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tilt_deg) && $stable(holding))
    else $error("stalled result changed");

endmodule

bind tilt_angle_with_deadband_hold_core tadh_checker u_tadh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_ch.valid),
  .in_ready  (sample_ch.ready),
  .out_valid (angle_ch.valid),
  .out_ready (angle_ch.ready),
  .tilt_deg  (angle_ch.tilt_deg),
  .holding   (angle_ch.holding)
);

`default_nettype wire
